[design/drd_pkg.sv]
// shared types, constants and saturation helper for the detection row decoder
package drd_pkg;

   localparam int unsigned ONE_Q      = 65536;
   localparam int unsigned NORM_LIMIT = 98304;
   localparam int unsigned MAX_CLASS  = 511;
   localparam int unsigned PROD_W     = 66;

   typedef enum logic [2:0] {
      CSR_CONF_THRESHOLD = 3'd0,
      CSR_HAS_OBJECTNESS = 3'd1,
      CSR_INPUT_WIDTH    = 3'd2,
      CSR_INPUT_HEIGHT   = 3'd3,
      CSR_INV_SCALE      = 3'd4,
      CSR_PAD_LEFT       = 3'd5,
      CSR_PAD_TOP        = 3'd6,
      CSR_IMAGE_SIZE     = 3'd7
   } csr_index_type;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_CONF  = 10'b00_0000_0010,
      ST_CHK   = 10'b00_0000_0100,
      ST_NMUL  = 10'b00_0000_1000,
      ST_NSAT  = 10'b00_0001_0000,
      ST_BOX   = 10'b00_0010_0000,
      ST_UMUL  = 10'b00_0100_0000,
      ST_URND  = 10'b00_1000_0000,
      ST_CLAMP = 10'b01_0000_0000,
      ST_OUT   = 10'b10_0000_0000
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(signed'(32'sh7FFF_FFFF));
      lo = PROD_W'(signed'(32'sh8000_0000));
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

[design/detection_row_decoder.sv]
// detection row decoder: per-element argmax and a sequenced row-end box unit
// each element is taken as it is accepted; a kept row gives its item at the end of the row-end
//   sequence (ST_CONF to ST_OUT), all row-end products going through one shared 33x33 multiplier
// throughput: one element per cycle inside a row; after a row of six or more
//   elements the input stalls while the row-end sequence runs
// reset: synchronous, clears control and row state; box and objectness storage is
//   not cleared
module detection_row_decoder
   import drd_pkg::*;
#(
   parameter int MAX_ROW_LENGTH = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_value,
   input  logic               req_row_last,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_box_left,
   output logic [15:0]        rsp_box_top,
   output logic [15:0]        rsp_box_width,
   output logic [15:0]        rsp_box_height,
   output logic signed [9:0]  rsp_class_id,
   output logic [30:0]        rsp_confidence,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int IDX_W = $clog2(MAX_ROW_LENGTH + 1);

   // configuration
   logic [16:0] conf_threshold_ff;
   logic        has_objectness_ff;
   logic [12:0] input_width_ff;
   logic [12:0] input_height_ff;
   logic [31:0] inv_scale_ff;
   logic [11:0] pad_left_ff;
   logic [11:0] pad_top_ff;
   logic [31:0] image_size_ff;

   // row state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic signed [31:0] bx_ff [4];
   logic signed [31:0] bx_in [4];
   logic signed [31:0] obj_ff, obj_in;
   logic signed [31:0] score_ff, score_in;
   logic signed [9:0]  cls_ff, cls_in;
   logic [2:0]         small_ff, small_in;
   logic               first_row_ff, first_row_in;
   logic               norm_ff, norm_in;

   // row-end work registers
   logic signed [31:0]       wscore_ff, wscore_in;
   logic signed [9:0]        wcls_ff, wcls_in;
   logic [1:0]               k_ff, k_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [30:0]              conf_ff, conf_in;
   logic signed [31:0]       wv_ff [4];
   logic signed [31:0]       wv_in [4];
   logic signed [17:0]       rv_ff [4];
   logic signed [17:0]       rv_in [4];
   logic [15:0]              res_x_ff, res_x_in;
   logic [15:0]              res_y_ff, res_y_in;
   logic [15:0]              res_w_ff, res_w_in;
   logic [15:0]              res_h_ff, res_h_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] out_x_ff, out_x_in;
   logic [15:0] out_y_ff, out_y_in;
   logic [15:0] out_w_ff, out_w_in;
   logic [15:0] out_h_ff, out_h_in;
   logic signed [9:0] out_cls_ff, out_cls_in;
   logic [30:0] out_conf_ff, out_conf_in;

   // shared multiplier operands
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic               mul_en;

   // element path
   logic               accept;
   logic [IDX_W-1:0]   idx_e;
   logic [IDX_W-1:0]   idx_n;
   logic [IDX_W-1:0]   cls_idx;
   logic signed [31:0] score_e;
   logic signed [9:0]  cls_e;
   logic [2:0]         small_e;
   logic               first_e;

   // row-end helpers
   logic signed [PROD_W-1:0] conf_q;
   logic signed [31:0]       b0, b1, b2, b3;
   logic signed [31:0]       cx, cy, cw, ch, sxw, syh;
   logic                     cx_ok;
   logic signed [33:0]       pad_q;
   logic signed [31:0]       tval;
   logic signed [31:0]       fval;
   logic signed [33:0]       rnd;
   logic signed [17:0]       img_w, img_h, hi_x, hi_y, x1, y1, hi_w, hi_h, w1, h1;
   logic                     out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_box_left   = out_x_ff;
   assign rsp_box_top    = out_y_ff;
   assign rsp_box_width  = out_w_ff;
   assign rsp_box_height = out_h_ff;
   assign rsp_class_id   = out_cls_ff;
   assign rsp_confidence = out_conf_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      obj_in       = obj_ff;
      score_in     = score_ff;
      cls_in       = cls_ff;
      small_in     = small_ff;
      first_row_in = first_row_ff;
      norm_in      = norm_ff;
      wscore_in    = wscore_ff;
      wcls_in      = wcls_ff;
      k_in         = k_ff;
      conf_in      = conf_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_w_in     = res_w_ff;
      res_h_in     = res_h_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_w_in     = out_w_ff;
      out_h_in     = out_h_ff;
      out_cls_in   = out_cls_ff;
      out_conf_in  = out_conf_ff;
      for (int i = 0; i < 4; i++) begin
         bx_in[i] = bx_ff[i];
         wv_in[i] = wv_ff[i];
         rv_in[i] = rv_ff[i];
      end

      idx_e   = req_frame_start ? '0 : idx_ff;
      score_e = req_frame_start ? 32'sd0 : score_ff;
      cls_e   = req_frame_start ? -10'sd1 : cls_ff;
      small_e = req_frame_start ? 3'd0 : small_ff;
      first_e = req_frame_start ? 1'b1 : first_row_ff;
      idx_n   = idx_e;
      cls_idx = idx_e - (has_objectness_ff ? IDX_W'(5) : IDX_W'(4));

      mul_a   = 33'(signed'(wv_ff[k_ff]));
      mul_b   = {1'b0, inv_scale_ff};
      mul_en  = 1'b0;
      prod_in = prod_ff;

      b0 = wv_ff[0];
      b1 = wv_ff[1];
      b2 = wv_ff[2];
      b3 = wv_ff[3];
      cx  = sat32(PROD_W'(b0) - PROD_W'(b2 >>> 1));
      cy  = sat32(PROD_W'(b1) - PROD_W'(b3 >>> 1));
      sxw = sat32(PROD_W'(cx) + PROD_W'(b2));
      syh = sat32(PROD_W'(cy) + PROD_W'(b3));
      cx_ok = (b2 > 32'sd65536) && (b3 > 32'sd65536) &&
              (sxw > 32'sd65536) && (syh > 32'sd65536);
      cw = sat32(PROD_W'(b2) - PROD_W'(b0));
      ch = sat32(PROD_W'(b3) - PROD_W'(b1));

      conf_q = prod_ff >>> 16;
      pad_q  = (k_ff == 2'd0) ? 34'(signed'({1'b0, pad_left_ff, 16'd0})) :
               (k_ff == 2'd1) ? 34'(signed'({1'b0, pad_top_ff, 16'd0})) : 34'sd0;
      tval   = sat32(PROD_W'(34'(signed'(wv_ff[k_ff])) - pad_q));
      fval   = sat32(prod_ff >>> 16);
      if (fval >= 0) begin
         rnd = (34'(signed'(fval)) + 34'sd32768) >>> 16;
      end else begin
         rnd = -((-34'(signed'(fval)) + 34'sd32768) >>> 16);
      end

      img_w = 18'(signed'({2'b0, image_size_ff[15:0]}));
      img_h = 18'(signed'({2'b0, image_size_ff[31:16]}));
      hi_x  = img_w - 18'sd1;
      hi_y  = img_h - 18'sd1;
      x1 = (rv_ff[0] > hi_x) ? hi_x : rv_ff[0];
      x1 = (x1 < 0) ? 18'sd0 : x1;
      y1 = (rv_ff[1] > hi_y) ? hi_y : rv_ff[1];
      y1 = (y1 < 0) ? 18'sd0 : y1;
      hi_w = img_w - x1;
      hi_h = img_h - y1;
      w1 = (rv_ff[2] > hi_w) ? hi_w : rv_ff[2];
      w1 = (w1 < 0) ? 18'sd0 : w1;
      h1 = (rv_ff[3] > hi_h) ? hi_h : rv_ff[3];
      h1 = (h1 < 0) ? 18'sd0 : h1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               score_in     = score_e;
               cls_in       = cls_e;
               small_in     = small_e;
               first_row_in = first_e;
               if (32'(idx_e) < 32'(MAX_ROW_LENGTH)) begin
                  if (32'(idx_e) < 32'd4) begin
                     bx_in[idx_e[1:0]] = req_value;
                     if (first_e && req_value <= 32'sd98304 && small_e < 3'd7) begin
                        small_in = small_e + 3'd1;
                     end
                  end else if (32'(idx_e) == 32'd4 && has_objectness_ff) begin
                     obj_in = req_value;
                  end else if (32'(cls_idx) <= 32'(MAX_CLASS) && req_value > score_e) begin
                     score_in = req_value;
                     cls_in   = 10'(cls_idx);
                  end
                  idx_n = idx_e + IDX_W'(1);
               end
               idx_in = idx_n;
               if (req_row_last) begin
                  if (first_e) begin
                     norm_in      = (small_in >= 3'd3);
                     first_row_in = 1'b0;
                  end
                  wscore_in = score_in;
                  wcls_in   = cls_in;
                  idx_in    = '0;
                  score_in  = 32'sd0;
                  cls_in    = -10'sd1;
                  if (32'(idx_n) >= 32'd6) begin
                     state_in = ST_CONF;
                  end
               end
            end
         end
         ST_CONF: begin
            mul_a    = has_objectness_ff ? 33'(signed'(obj_ff)) : 33'sd65536;
            mul_b    = 33'(signed'(wscore_ff));
            mul_en   = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            conf_in = (conf_q > PROD_W'(32'sh7FFF_FFFF)) ? 31'h7FFF_FFFF : conf_q[30:0];
            k_in    = 2'd0;
            if (prod_ff < 0 || conf_in < 31'(conf_threshold_ff)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_NMUL;
            end
         end
         ST_NMUL: begin
            mul_a    = 33'(signed'(bx_ff[k_ff]));
            mul_b    = k_ff[0] ? 33'(signed'({1'b0, input_height_ff}))
                               : 33'(signed'({1'b0, input_width_ff}));
            mul_en   = 1'b1;
            state_in = ST_NSAT;
         end
         ST_NSAT: begin
            wv_in[k_ff] = norm_ff ? sat32(prod_ff) : bx_ff[k_ff];
            k_in        = k_ff + 2'd1;
            state_in    = (k_ff == 2'd3) ? ST_BOX : ST_NMUL;
         end
         ST_BOX: begin
            if (cx_ok) begin
               wv_in[0] = cx;
               wv_in[1] = cy;
            end else begin
               wv_in[2] = cw;
               wv_in[3] = ch;
            end
            k_in     = 2'd0;
            state_in = ST_UMUL;
         end
         ST_UMUL: begin
            mul_a    = 33'(signed'(tval));
            mul_b    = {1'b0, inv_scale_ff};
            mul_en   = 1'b1;
            state_in = ST_URND;
         end
         ST_URND: begin
            rv_in[k_ff] = rnd[17:0];
            k_in        = k_ff + 2'd1;
            state_in    = (k_ff == 2'd3) ? ST_CLAMP : ST_UMUL;
         end
         ST_CLAMP: begin
            res_x_in = x1[15:0];
            res_y_in = y1[15:0];
            res_w_in = w1[15:0];
            res_h_in = h1[15:0];
            if (rv_ff[2] <= 18'sd1 || rv_ff[3] <= 18'sd1 || w1 == 18'sd0 || h1 == 18'sd0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_x_in     = res_x_ff;
               out_y_in     = res_y_ff;
               out_w_in     = res_w_ff;
               out_h_in     = res_h_ff;
               out_cls_in   = wcls_ff;
               out_conf_in  = conf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // one shared multiplier for every row-end product
      if (mul_en) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_threshold_ff <= 17'd16384;
         has_objectness_ff <= 1'b0;
         input_width_ff    <= 13'd640;
         input_height_ff   <= 13'd640;
         inv_scale_ff      <= 32'd65536;
         pad_left_ff       <= 12'd0;
         pad_top_ff        <= 12'd0;
         image_size_ff     <= 32'd47187200;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_CONF_THRESHOLD: conf_threshold_ff <= csr_data[16:0];
            CSR_HAS_OBJECTNESS: has_objectness_ff <= csr_data[0];
            CSR_INPUT_WIDTH:    input_width_ff    <= csr_data[12:0];
            CSR_INPUT_HEIGHT:   input_height_ff   <= csr_data[12:0];
            CSR_INV_SCALE:      inv_scale_ff      <= csr_data;
            CSR_PAD_LEFT:       pad_left_ff       <= csr_data[11:0];
            CSR_PAD_TOP:        pad_top_ff        <= csr_data[11:0];
            CSR_IMAGE_SIZE:     image_size_ff     <= csr_data;
            default:            image_size_ff     <= image_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         score_ff     <= 32'sd0;
         cls_ff       <= -10'sd1;
         small_ff     <= 3'd0;
         first_row_ff <= 1'b0;
         norm_ff      <= 1'b0;
         k_ff         <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         score_ff     <= score_in;
         cls_ff       <= cls_in;
         small_ff     <= small_in;
         first_row_ff <= first_row_in;
         norm_ff      <= norm_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      obj_ff      <= obj_in;
      wscore_ff   <= wscore_in;
      wcls_ff     <= wcls_in;
      prod_ff     <= prod_in;
      conf_ff     <= conf_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_w_ff    <= res_w_in;
      res_h_ff    <= res_h_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_w_ff    <= out_w_in;
      out_h_ff    <= out_h_in;
      out_cls_ff  <= out_cls_in;
      out_conf_ff <= out_conf_in;
      for (int i = 0; i < 4; i++) begin
         bx_ff[i] <= bx_in[i];
         wv_ff[i] <= wv_in[i];
         rv_ff[i] <= rv_in[i];
      end
   end

`ifndef SYNTHESIS
   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> rsp_valid_ff)
      else $error("result not loaded from output state");

   a_box_starts_unlb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BOX) |=> (state_ff == ST_UMUL && k_ff == 2'd0))
      else $error("unletterbox pass did not start at first value");

   a_conf_above_thr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_confidence >= 31'(conf_threshold_ff)))
      else $error("item below confidence threshold");

   a_nonempty_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_box_width != 16'd0 && rsp_box_height != 16'd0))
      else $error("empty box delivered");
`endif

endmodule

[tb/sv/detection_row_decoder_checker.sv]
// checker for the detection row decoder: watches the channels, predicts boxes and compares
module detection_row_decoder_checker
   import drd_pkg::*;
#(
   parameter int MAX_ROW_LENGTH = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_value,
   input  logic               req_row_last,
   input  logic               req_frame_start,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [15:0]        rsp_box_left,
   input  logic [15:0]        rsp_box_top,
   input  logic [15:0]        rsp_box_width,
   input  logic [15:0]        rsp_box_height,
   input  logic signed [9:0]  rsp_class_id,
   input  logic [30:0]        rsp_confidence,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 error_count,
   output int                 pending_boxes,
   output int                 boxes_checked
);

   localparam longint ONE  = 65536;
   localparam longint NORM = 98304;

   typedef struct {
      logic [15:0]       left;
      logic [15:0]       top;
      logic [15:0]       width;
      logic [15:0]       height;
      logic signed [9:0] class_id;
      logic [30:0]       confidence;
   } box_type;

   box_type box_queue[$];

   // register copies
   logic [16:0] conf_threshold;
   logic        has_obj;
   logic [12:0] in_width;
   logic [12:0] in_height;
   logic [31:0] inv_scale;
   logic [11:0] pad_left;
   logic [11:0] pad_top;
   logic [31:0] image_size;

   // row state
   int                 elem_idx;
   logic signed [31:0] box_val[4];
   logic signed [31:0] obj_val;
   logic signed [31:0] best_score;
   int                 best_class;
   int                 small_cnt;
   bit                 first_row;
   bit                 norm_flag;

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unletterbox(input longint v, input longint pad);
      longint t;
      t = sat32(v - pad * ONE);
      return sat32((t * longint'({32'b0, inv_scale})) >>> 16);
   endfunction

   function automatic longint round_px(input longint v);
      if (v >= 0) return (v + ONE / 2) >>> 16;
      return -((-v + ONE / 2) >>> 16);
   endfunction

   task automatic decode_element(input logic signed [31:0] v, input bit last, input bit fs);
      int      cls;
      int      len;
      int      score_cls;
      longint  score;
      longint  obj;
      longint  prod;
      longint  conf;
      longint  b[4];
      longint  x;
      longint  y;
      longint  w;
      longint  h;
      longint  img_w;
      longint  img_h;
      bit      center_ok;
      box_type r;
      if (fs) begin
         elem_idx = 0;
         best_score = 0;
         best_class = -1;
         small_cnt = 0;
         first_row = 1;
      end
      if (elem_idx < MAX_ROW_LENGTH) begin
         if (elem_idx < 4) begin
            box_val[elem_idx] = v;
            if (first_row && longint'(v) <= NORM && small_cnt < 7) small_cnt++;
         end else if (elem_idx == 4 && has_obj) begin
            obj_val = v;
         end else begin
            cls = elem_idx - (has_obj ? 5 : 4);
            if (cls <= MAX_CLASS && v > best_score) begin
               best_score = v;
               best_class = cls;
            end
         end
         elem_idx++;
      end
      if (!last) return;
      len = elem_idx;
      if (first_row) begin
         norm_flag = small_cnt >= 3;
         first_row = 0;
      end
      score = best_score;
      score_cls = best_class;
      elem_idx = 0;
      best_score = 0;
      best_class = -1;
      if (len < 6) return;
      obj = has_obj ? longint'(obj_val) : ONE;
      prod = obj * score;
      if (prod < 0) return;
      conf = prod >>> 16;
      if (conf > 64'sh7FFFFFFF) conf = 64'sh7FFFFFFF;
      if (conf < longint'(conf_threshold)) return;
      for (int i = 0; i < 4; i++) begin
         b[i] = box_val[i];
         if (norm_flag) b[i] = sat32(b[i] * longint'((i & 1) ? in_height : in_width));
      end
      x = sat32(b[0] - (b[2] >>> 1));
      y = sat32(b[1] - (b[3] >>> 1));
      w = b[2];
      h = b[3];
      center_ok = w > ONE && h > ONE && sat32(x + w) > ONE && sat32(y + h) > ONE;
      if (!center_ok) begin
         x = b[0];
         y = b[1];
         w = sat32(b[2] - b[0]);
         h = sat32(b[3] - b[1]);
      end
      x = round_px(unletterbox(x, pad_left));
      y = round_px(unletterbox(y, pad_top));
      w = round_px(unletterbox(w, 0));
      h = round_px(unletterbox(h, 0));
      if (w <= 1 || h <= 1) return;
      img_w = image_size[15:0];
      img_h = image_size[31:16];
      if (x > img_w - 1) x = img_w - 1;
      if (x < 0) x = 0;
      if (y > img_h - 1) y = img_h - 1;
      if (y < 0) y = 0;
      if (w > img_w - x) w = img_w - x;
      if (w < 0) w = 0;
      if (h > img_h - y) h = img_h - y;
      if (h < 0) h = 0;
      if (w <= 0 || h <= 0) return;
      r.left = x[15:0];
      r.top = y[15:0];
      r.width = w[15:0];
      r.height = h[15:0];
      r.class_id = score_cls[9:0];
      r.confidence = conf[30:0];
      box_queue = {box_queue, r};
   endtask

   always @(posedge clock) begin
      box_type e;
      if (reset) begin
         conf_threshold = 17'd16384;
         has_obj = 0;
         in_width = 13'd640;
         in_height = 13'd640;
         inv_scale = 32'd65536;
         pad_left = 0;
         pad_top = 0;
         image_size = 32'd47187200;
         elem_idx = 0;
         best_score = 0;
         best_class = -1;
         small_cnt = 0;
         first_row = 0;
         norm_flag = 0;
         for (int i = 0; i < 4; i++) box_val[i] = 0;
         obj_val = 0;
         box_queue.delete();
         error_count = 0;
         boxes_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_CONF_THRESHOLD: conf_threshold = csr_data[16:0];
               CSR_HAS_OBJECTNESS: has_obj = csr_data[0];
               CSR_INPUT_WIDTH:    in_width = csr_data[12:0];
               CSR_INPUT_HEIGHT:   in_height = csr_data[12:0];
               CSR_INV_SCALE:      inv_scale = csr_data;
               CSR_PAD_LEFT:       pad_left = csr_data[11:0];
               CSR_PAD_TOP:        pad_top = csr_data[11:0];
               CSR_IMAGE_SIZE:     image_size = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (box_queue.size() == 0) begin
               $error("unexpected box item: left %0d top %0d", rsp_box_left, rsp_box_top);
               error_count++;
            end else begin
               e = box_queue.pop_front();
               boxes_checked++;
               if (rsp_box_left !== e.left) begin
                  $error("box_left exp %0d got %0d", e.left, rsp_box_left);
                  error_count++;
               end
               if (rsp_box_top !== e.top) begin
                  $error("box_top exp %0d got %0d", e.top, rsp_box_top);
                  error_count++;
               end
               if (rsp_box_width !== e.width) begin
                  $error("box_width exp %0d got %0d", e.width, rsp_box_width);
                  error_count++;
               end
               if (rsp_box_height !== e.height) begin
                  $error("box_height exp %0d got %0d", e.height, rsp_box_height);
                  error_count++;
               end
               if (rsp_class_id !== e.class_id) begin
                  $error("class_id exp %0d got %0d", e.class_id, rsp_class_id);
                  error_count++;
               end
               if (rsp_confidence !== e.confidence) begin
                  $error("confidence exp %0d got %0d", e.confidence, rsp_confidence);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            decode_element(req_value, req_row_last, req_frame_start);
      end
      pending_boxes = box_queue.size();
   end

endmodule

[tb/sv/detection_row_decoder_tb.sv]
// testbench top for the detection row decoder: stimulus, stall patterns and verdict
module detection_row_decoder_tb
   import drd_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TARGET_ITEMS   = 1850;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [31:0] req_value = 0;
   logic               req_row_last = 0;
   logic               req_frame_start = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [15:0]        rsp_box_left;
   logic [15:0]        rsp_box_top;
   logic [15:0]        rsp_box_width;
   logic [15:0]        rsp_box_height;
   logic signed [9:0]  rsp_class_id;
   logic [30:0]        rsp_confidence;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [2:0]         csr_index = 0;
   logic [31:0]        csr_data = 0;

   int error_count;
   int pending_boxes;
   int boxes_checked;
   int items_sent = 0;
   int rows_sent = 0;
   int idle_cycles = 0;
   bit no_idle = 0;
   bit long_hold = 0;
   bit has_obj = 0;

   always #5 clock = ~clock;

   detection_row_decoder u_dut (.*);

   detection_row_decoder_checker u_checker (.*);

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // result side stall pattern
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 7);
         if (long_hold) begin
            n = 300;
            long_hold = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_element(input logic [31:0] v, input bit last, input bit fs);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_value <= v;
      req_row_last <= last;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending_boxes != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] thr, input bit obj, input logic [31:0] iw,
                             input logic [31:0] ih, input logic [31:0] inv,
                             input logic [31:0] pl, input logic [31:0] pt,
                             input logic [31:0] img);
      wait_drained();
      write_reg(CSR_CONF_THRESHOLD, thr);
      write_reg(CSR_HAS_OBJECTNESS, obj);
      write_reg(CSR_INPUT_WIDTH, iw);
      write_reg(CSR_INPUT_HEIGHT, ih);
      write_reg(CSR_INV_SCALE, inv);
      write_reg(CSR_PAD_LEFT, pl);
      write_reg(CSR_PAD_TOP, pt);
      write_reg(CSR_IMAGE_SIZE, img);
      csr_valid <= 0;
      has_obj = obj;
   endtask

   function automatic logic [31:0] px(input int lo, input int hi);
      return {16'($urandom_range(lo, hi)), 16'h0} | 32'($urandom_range(0, 65535));
   endfunction

   // one detection row; mode 0 centre pixels, 1 normalized, 2 corner, 3 noise
   task automatic send_row(input int len, input bit fs, input int mode);
      logic [31:0] v;
      logic [31:0] x0;
      logic [31:0] y0;
      for (int i = 0; i < len; i++) begin
         if (mode == 3 || $urandom_range(0, 40) == 0) v = $urandom;
         else if (i < 4) begin
            case (mode)
               0: v = (i < 2) ? px(0, 1300) : px(2, 400);
               1: v = $urandom_range(0, (i < 2) ? 65536 : 40000);
               default: begin
                  if (i == 0) begin x0 = px(0, 1000); v = x0; end
                  else if (i == 1) begin y0 = px(0, 700); v = y0; end
                  else v = ((i == 2) ? x0 : y0) + px(0, 300);
               end
            endcase
         end else if (i == 4 && has_obj) v = $urandom_range(0, 65536);
         else v = $urandom_range(0, 73728) - 8192;
         send_element(v, i == len - 1, fs && i == 0);
      end
      rows_sent++;
   endtask

   function automatic int row_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 8) return $urandom_range(1, 5);
      if (p < 10) return (p == 8) ? 520 : $urandom_range(30, 100);
      return $urandom_range(6, 14);
   endfunction

   initial begin
      int phase;
      int mode;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rows, first under reset settings and then under corner-case settings
      send_row(6, 1, 1);
      send_row(5, 0, 0);
      send_element(32'h7FFF_FFFF, 0, 0);
      send_element(32'h8000_0000, 0, 0);
      send_element(32'h0001_0000, 0, 0);
      send_element(32'h0040_0000, 0, 1);
      send_element(32'h0030_0000, 0, 0);
      send_element(32'h0100_0000, 0, 0);
      send_element(32'h00A0_0000, 0, 0);
      send_element(32'h8000_0000, 0, 0);
      send_element(32'h0001_0000, 1, 0);
      send_row(6, 0, 2);
      set_config(0, 1, 4096, 1, 0, 4095, 4095, 0);
      send_row(7, 1, 0);
      set_config(65536, 0, 4096, 4096, 32'hFFFF_FFFF, 4095, 4095, 32'hFFFF_FFFF);
      send_row(6, 0, 3);
      set_config(0, 1, 1, 1, 1, 0, 0, 32'h0001_0001);
      send_row(8, 1, 1);

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         if (phase == 2) long_hold = 1;
         if (phase % 4 == 0)
            set_config($urandom_range(0, 65536), $urandom_range(0, 1), $urandom_range(1, 4096),
                       $urandom_range(1, 4096), $urandom, $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom);
         else
            set_config($urandom_range(0, 20000), $urandom_range(0, 1), 640,
                       $urandom_range(320, 1024), $urandom_range(32768, 131072),
                       $urandom_range(0, 80), $urandom_range(0, 80),
                       {16'($urandom_range(200, 2000)), 16'h0} |
                       32'($urandom_range(200, 2000)));
         no_idle = (phase % 3 == 1);
         repeat (25) begin
            mode = $urandom_range(0, 2);
            send_row(row_length(), 1, mode);
            repeat ($urandom_range(0, 6))
               send_row(row_length(), 0, ($urandom_range(0, 19) == 0) ? 3 : mode);
            if (items_sent >= TARGET_ITEMS) break;
         end
         phase++;
      end
      no_idle = 0;
      wait_drained();
      $display("sent %0d elements in %0d rows over %0d setting phases", items_sent, rows_sent,
               phase + 4);
      $display("checked %0d boxes", boxes_checked);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
